/* sv/lsip_pkg.sv */
// ----------------------------------------------------------------------------
// lsip_pkg
// Shared constants and types for the LIFO stack with indexed peek.
// ----------------------------------------------------------------------------
package lsip_pkg;

    // Field widths
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned INDEX_W  = 7;
    localparam int unsigned STATUS_W = 3;

    // Default stack depth, range 2 to 64
    localparam int unsigned STACK_DEPTH_DEF = 64;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_DISPLAY = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_POP     = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_PEEK    = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WRONG_INDEX = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd4;

    // One result item
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } result_t;

endpackage

/* sv/lsip_ram.sv */
// ----------------------------------------------------------------------------
// lsip_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while no read is enabled.
// ----------------------------------------------------------------------------
module lsip_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/lsip_ctrl.sv */
// ----------------------------------------------------------------------------
// lsip_ctrl
// Stack controller: keeps the entry count, drives the stack memory and
// sequences peek and display reads into the registered result stage.
// ----------------------------------------------------------------------------
module lsip_ctrl #(
    parameter int unsigned STACK_DEPTH = lsip_pkg::STACK_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input item
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lsip_pkg::OPCODE_W-1:0]        opcode,
    input  logic signed [lsip_pkg::DATA_W-1:0]   push_value,
    input  logic [lsip_pkg::INDEX_W-1:0]         peek_index,
    // Result item
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output lsip_pkg::result_t                    result,
    // Stack memory
    output logic                                 wr_en,
    output logic [$clog2(STACK_DEPTH)-1:0]       wr_addr,
    output logic [lsip_pkg::DATA_W-1:0]          wr_data,
    output logic                                 rd_en,
    output logic [$clog2(STACK_DEPTH)-1:0]       rd_addr,
    input  logic [lsip_pkg::DATA_W-1:0]          rd_data
);

    import lsip_pkg::*;

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic                 state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic                 peek_reg, peek_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;

    logic                 out_free;
    logic                 accept;
    logic [INDEX_W-1:0]   count_ext;
    logic                 emit_last;

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign count_ext = INDEX_W'(count_reg);
    assign emit_last = peek_reg || (pos_reg == '0);

    // Decode operations and sequence memory reads
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        peek_next      = peek_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_addr        = AW'(count_reg);
        wr_data        = push_value;
        rd_en          = 1'b0;
        rd_addr        = pos_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    out_valid_next = 1'b1;
                    out_next.value = '0;
                    out_next.last  = 1'b1;
                    unique case (opcode)
                        OP_PUSH: begin
                            if (count_reg == CW'(STACK_DEPTH)) begin
                                out_next.status = ST_OVERFLOW;
                            end else begin
                                wr_en           = 1'b1;
                                count_next      = count_reg + 1'b1;
                                out_next.status = ST_OK;
                            end
                        end
                        OP_POP: begin
                            if (count_reg == '0) begin
                                out_next.status = ST_UNDERFLOW;
                            end else begin
                                count_next      = count_reg - 1'b1;
                                out_next.status = ST_OK;
                            end
                        end
                        OP_PEEK: begin
                            if (count_reg == '0) begin
                                out_next.status = ST_EMPTY;
                            end else if (peek_index == '0 || peek_index > count_ext) begin
                                out_next.status = ST_WRONG_INDEX;
                            end else begin
                                // Read the entry; S_EMIT then loads the read data into the result register
                                out_valid_next = 1'b0;
                                rd_en          = 1'b1;
                                rd_addr        = AW'(count_ext - peek_index);
                                peek_next      = 1'b1;
                                state_next     = S_EMIT;
                            end
                        end
                        OP_DISPLAY: begin
                            if (count_reg == '0) begin
                                out_next.status = ST_EMPTY;
                            end else begin
                                // Start at the top entry
                                out_valid_next = 1'b0;
                                rd_en          = 1'b1;
                                rd_addr        = AW'(count_reg - 1'b1);
                                pos_next       = AW'(count_reg - 1'b1);
                                peek_next      = 1'b0;
                                state_next     = S_EMIT;
                            end
                        end
                    endcase
                end
            end
            S_EMIT: begin
                // Move read data out, fetch the next entry down
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_next.value  = rd_data;
                    out_next.status = ST_OK;
                    out_next.last   = emit_last;
                    if (emit_last) begin
                        state_next = S_IDLE;
                    end else begin
                        pos_next = pos_reg - 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = pos_reg - 1'b1;
                    end
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        peek_reg <= peek_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

endmodule

/* sv/lifo_stack_indexed_peek_top.sv */
// ----------------------------------------------------------------------------
// lifo_stack_indexed_peek_top
// Bounded LIFO stack of signed 32-bit words with push, pop, indexed peek and
// a full top-to-bottom display, on streaming input and result channels.
// ----------------------------------------------------------------------------
// The stack lives in one memory with a registered read. Push, pop, empty
// or out-of-range peek and display of an empty stack give one result item.
// A peek in range first reads the memory, then loads the read data into the
// result register. Display starts with one read, then gives one result item
// per cycle from the single read port while m_tready does not hold it back,
// top first, with m_tlast on the bottom entry. A result register sits on the
// output. When no peek or display read sequence is running, a new item is
// taken in the same cycle as the waiting result leaves. A result held back by
// m_tready holds off the input. Status in m_tuser: 0 ok, 1 empty, 2 underflow,
// 3 wrong index, 4 overflow; value is zero unless an entry is read.
// ----------------------------------------------------------------------------
module lifo_stack_indexed_peek_top #(
    parameter int unsigned STACK_DEPTH = lsip_pkg::STACK_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] push_value, [38:32] peek_index, [39] zero
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);

    import lsip_pkg::*;

    localparam int unsigned AW = $clog2(STACK_DEPTH);

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [DATA_W-1:0]    wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [DATA_W-1:0]    rd_data;
    result_t              result;

    // Stack controller
    lsip_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .opcode     (s_tuser[OPCODE_W-1:0]),
        .push_value (s_tdata[DATA_W-1:0]),
        .peek_index (s_tdata[DATA_W+INDEX_W-1:DATA_W]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result     (result),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    // Stack memory
    lsip_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Pack the result item
    assign m_tdata = result.value;
    assign m_tuser = result.status;
    assign m_tlast = result.last;

endmodule

/* test/lsip_checker.sv */
// ----------------------------------------------------------------------------
// lsip_checker
// Watches both channels of the LIFO stack, keeps its own copy of the stack
// and compares every result item, field by field, against the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module lsip_checker #(
    parameter int unsigned DEPTH = lsip_pkg::STACK_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] push_value, [38:32] peek_index, [39] zero
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] value
    input  logic [2:0]  m_tuser,   // [2:0] status
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    import lsip_pkg::*;

    // Shadow stack, entry 0 at the bottom
    logic signed [DATA_W-1:0] shadow_mem [0:DEPTH-1];
    int unsigned              shadow_count;

    // Predicted result items, oldest first
    result_t awaited_results[$];
    result_t oldest;

    task automatic queue_result(input logic signed [DATA_W-1:0] value,
                                input logic [STATUS_W-1:0] status,
                                input logic last);
        result_t r;
        r.value  = value;
        r.status = status;
        r.last   = last;
        awaited_results.push_back(r);
    endtask

    // Apply one operation to the shadow stack and queue what it yields
    task automatic stack_outcome(input logic [OPCODE_W-1:0] op,
                                 input logic signed [DATA_W-1:0] word,
                                 input logic [INDEX_W-1:0] idx);
        int unsigned pos;
        case (op)
            OP_PUSH: begin
                if (shadow_count >= DEPTH) begin
                    queue_result('0, ST_OVERFLOW, 1'b1);
                end else begin
                    shadow_mem[shadow_count] = word;
                    shadow_count++;
                    queue_result('0, ST_OK, 1'b1);
                end
            end
            OP_POP: begin
                if (shadow_count == 0) begin
                    queue_result('0, ST_UNDERFLOW, 1'b1);
                end else begin
                    shadow_count--;
                    queue_result('0, ST_OK, 1'b1);
                end
            end
            OP_PEEK: begin
                if (shadow_count == 0)
                    queue_result('0, ST_EMPTY, 1'b1);
                else if (idx == 0 || idx > shadow_count)
                    queue_result('0, ST_WRONG_INDEX, 1'b1);
                else
                    queue_result(shadow_mem[shadow_count - idx], ST_OK, 1'b1);
            end
            default: begin
                // Display: whole stack top first, last on the bottom entry
                if (shadow_count == 0) begin
                    queue_result('0, ST_EMPTY, 1'b1);
                end else begin
                    pos = shadow_count;
                    while (pos > 0) begin
                        pos--;
                        queue_result(shadow_mem[pos], ST_OK, pos == 0);
                    end
                end
            end
        endcase
    endtask

    // Predict on each accepted input item, compare on each accepted result
    always @(posedge aclk) begin
        if (!aresetn) begin
            shadow_count = 0;
            awaited_results.delete();
            fail_count = 0;
        end else begin
            if (s_tvalid && s_tready)
                stack_outcome(s_tuser, s_tdata[31:0], s_tdata[38:32]);
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result item: value %0d status %0d last %0b",
                           $signed(m_tdata), m_tuser, m_tlast);
                    fail_count++;
                end else begin
                    oldest = awaited_results.pop_front();
                    if (m_tdata !== oldest.value) begin
                        $error("value mismatch: expected %0d, actual %0d",
                               oldest.value, $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tuser !== oldest.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               oldest.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tlast !== oldest.last) begin
                        $error("last mismatch: expected %0b, actual %0b",
                               oldest.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        pending = awaited_results.size();
    end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives directed and random stack operations into the LIFO stack with
// indexed peek, stalls both channels at random, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
    import lsip_pkg::*;

    localparam int unsigned DEPTH      = STACK_DEPTH_DEF;
    localparam int          RAND_ITEMS = 190;
    localparam int          IDLE_LIMIT = 1000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int pending;
    int idle_cycles;
    int stack_fill;
    bit calm;

    lifo_stack_indexed_peek_top #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    lsip_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // Clock, period 2
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Stall the result channel in random bursts, never in the calm phase
    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
                m_tready = 1'b1;
            end
        end
    end

    // Any peek index over the full field range
    function automatic logic [INDEX_W-1:0] rand_index();
        return INDEX_W'($urandom_range(0, 127));
    endfunction

    // Send one item, optionally after a random gap; return at the negedge
    // after it was taken
    task automatic send_op(input logic [OPCODE_W-1:0] op,
                           input logic [DATA_W-1:0] word,
                           input logic [INDEX_W-1:0] idx);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {1'b0, idx, word};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        // Track fill level to steer the random part
        if (op == OP_PUSH && stack_fill < DEPTH)
            stack_fill++;
        else if (op == OP_POP && stack_fill > 0)
            stack_fill--;
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    initial begin
        int n;
        int r;
        int mode;
        int overflow_hits;
        logic [OPCODE_W-1:0] op;
        logic [INDEX_W-1:0]  idx;

        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_DISPLAY;
        calm       = 1'b0;
        stack_fill = 0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Empty stack: display, underflow, empty peek
        send_op(OP_DISPLAY, $urandom(), rand_index());
        send_op(OP_POP,     $urandom(), rand_index());
        send_op(OP_PEEK,    $urandom(), 7'd1);
        send_op(OP_PEEK,    $urandom(), 7'd0);
        // Extreme words
        send_op(OP_PUSH, 32'h7FFF_FFFF, 7'h7F);
        send_op(OP_PUSH, 32'h8000_0000, 7'h00);
        send_op(OP_PUSH, 32'h0000_0000, 7'h7F);
        send_op(OP_PUSH, 32'hFFFF_FFFF, 7'h00);
        send_op(OP_PUSH, 32'h5555_AAAA, 7'h2A);
        // Peek at index zero, top, bottom, one past the bottom, maximum
        send_op(OP_PEEK, $urandom(), 7'd0);
        send_op(OP_PEEK, $urandom(), 7'd1);
        send_op(OP_PEEK, $urandom(), 7'd5);
        send_op(OP_PEEK, $urandom(), 7'd6);
        send_op(OP_PEEK, $urandom(), 7'd127);
        send_op(OP_DISPLAY, $urandom(), rand_index());
        send_op(OP_POP,     $urandom(), rand_index());
        send_op(OP_PEEK,    $urandom(), 7'd4);
        send_op(OP_DISPLAY, $urandom(), rand_index());
        repeat (4) send_op(OP_POP, $urandom(), rand_index());
        send_op(OP_POP,     $urandom(), rand_index());
        send_op(OP_DISPLAY, $urandom(), rand_index());
        drain_results();

        // Random part: fill to overflow, mix, then drain to underflow
        mode          = 0;
        overflow_hits = 0;
        for (n = 0; n < RAND_ITEMS; n++) begin
            calm = (n >= RAND_ITEMS - 30);
            if (n == 100)
                drain_results();
            if (mode == 0 && overflow_hits >= 3)
                mode = 1;
            if (n >= 140)
                mode = 2;

            r = $urandom_range(0, 99);
            if (mode == 0)
                op = (r < 88) ? OP_PUSH : (r < 94) ? OP_PEEK : (r < 97) ? OP_POP : OP_DISPLAY;
            else if (mode == 1)
                op = (r < 30) ? OP_PUSH : (r < 55) ? OP_PEEK : (r < 85) ? OP_POP : OP_DISPLAY;
            else
                op = (r < 65) ? OP_POP : (r < 80) ? OP_PEEK : (r < 92) ? OP_PUSH : OP_DISPLAY;
            if (op == OP_PUSH && stack_fill == DEPTH)
                overflow_hits++;

            // Peek index: mostly in range, some at the edges and beyond
            r = $urandom_range(0, 9);
            if (r < 2 || stack_fill == 0)
                idx = rand_index();
            else if (r == 2)
                idx = '0;
            else if (r == 3)
                idx = INDEX_W'(stack_fill + 1);
            else
                idx = INDEX_W'($urandom_range(1, stack_fill));

            send_op(op, $urandom(), idx);
        end

        // Wait out every outstanding result, then a short tail
        drain_results();
        repeat (10) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
